@@ src/swm_pkg.sv @@
// Shared types and constants of the sliding window maximum filter.
package swm_pkg;

	localparam int CFG_WIDTH = 11;

	// Handoff from the cell row to the output stage.
	typedef struct packed {
		logic valid;
		logic last;
	} swm_ctl_t;

endpackage

@@ src/swm_if.sv @@
// Valid/ready channel interfaces for samples and results.
interface swm_in_if #(parameter int SAMPLE_WIDTH = 32);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           start_req;
	logic                           last_sample;

	modport source(output valid, sample, start_req, last_sample, input ready);
	modport sink(input valid, sample, start_req, last_sample, output ready);
endinterface

interface swm_out_if #(parameter int SAMPLE_WIDTH = 32);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] window_max;
	logic                           last_result;

	modport source(output valid, window_max, last_result, input ready);
	modport sink(input valid, window_max, last_result, output ready);
endinterface

@@ src/swm_cell.sv @@
// One cell of the row: holds the maximum of the latest samples up to its depth.
module swm_cell #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           start_req,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] prev_max,
	output logic signed [SAMPLE_WIDTH-1:0] max_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			// forget history on a new sequence, else fold the sample into the neighbor's max
			if (start_req || (sample > prev_max)) begin
				max_q <= sample;
			end else begin
				max_q <= prev_max;
			end
		end
	end

endmodule

@@ src/swm_tap.sv @@
// Output stage: picks the cell at the current span and holds the result beat.
module swm_tap import swm_pkg::*; #(
	parameter int WINDOW_MAX   = 1024,
	parameter int SAMPLE_WIDTH = 32,
	parameter int IW           = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swm_ctl_t                       ctl,
	input  logic [IW-1:0]                  tap,
	input  logic signed [SAMPLE_WIDTH-1:0] cells [WINDOW_MAX],
	output logic                           free,
	swm_out_if.source                      results
);

	logic                           valid_q;
	logic signed [SAMPLE_WIDTH-1:0] max_q;
	logic                           last_q;

	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && ctl.valid) begin
			max_q  <= cells[tap];
			last_q <= ctl.last;
		end
	end

	assign results.valid       = valid_q;
	assign results.window_max  = max_q;
	assign results.last_result = last_q;

endmodule

@@ src/sliding_window_maximum.sv @@
// Sliding window maximum filter over a signed sample stream.
// Samples arrive on the samples channel, one beat per sample, with start_req
// opening a new sequence and last_sample copied onto that sample's result.
// Once a sequence holds at least window_size samples, every sample gives one
// result beat on the results channel: the maximum of the latest window_size
// samples. Earlier samples of a sequence give no beat.
// window_size is written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, which the block does not enforce; zero acts as one and values above WINDOW_MAX act as WINDOW_MAX.
// A row of WINDOW_MAX cells holds, in cell k, the maximum of the latest k+1
// samples; each accepted sample updates every cell from its neighbor in the
// same cycle. The output stage reads the cell at the current span into a
// register; the span follows window_size but, after the window grows, regrows
// by one sample at a time.
// Throughput is one sample per cycle while the receiver keeps up; a sample is
// registered in the cell row, then its result in the output register. When the
// receiver stalls, the output register holds its beat and one more result waits
// in the cell row; further samples are then refused until the output drains.
// Reset sets window_size to 1 and empties the sequence; it takes effect at
// once, with no clearing pass.
module sliding_window_maximum import swm_pkg::*; #(
	parameter int WINDOW_MAX   = 1024,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_WIDTH-1:0] cfg_wdata,
	swm_in_if.sink               samples,
	swm_out_if.source            results
);

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int AW = ($clog2(WINDOW_MAX + 1) > CFG_WIDTH) ? $clog2(WINDOW_MAX + 1) : CFG_WIDTH;

	logic [AW-1:0]                  window_q;
	logic [AW-1:0]                  seen_q;
	logic [AW-1:0]                  seen_base;
	logic [AW-1:0]                  seen_next;
	logic [AW-1:0]                  span_q;
	logic [AW-1:0]                  span_base;
	logic [AW-1:0]                  span_next;
	logic [AW-1:0]                  cfg_ext;
	swm_ctl_t                       ctl_s1;
	logic                           out_free;
	logic                           accept;
	logic                           emit;
	logic [IW-1:0]                  tap;
	logic signed [SAMPLE_WIDTH-1:0] cell_max [WINDOW_MAX];

	assign cfg_ext = AW'(cfg_wdata);

	// Clamp the window when it is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= AW'(1);
		end else if (cfg_we) begin
			if (cfg_ext == '0) begin
				window_q <= AW'(1);
			end else if (cfg_ext > AW'(WINDOW_MAX)) begin
				window_q <= AW'(WINDOW_MAX);
			end else begin
				window_q <= cfg_ext;
			end
		end
	end

	assign tap = IW'(span_q - AW'(1));

	assign samples.ready = !ctl_s1.valid || out_free;
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		seen_base = samples.start_req ? '0 : seen_q;
		seen_next = (seen_base < window_q) ? seen_base + AW'(1) : seen_base;
		emit      = (seen_next >= window_q);
		// grow the span by one per sample, cut it to the window
		span_base = samples.start_req ? '0 : span_q;
		span_next = (span_base < window_q) ? span_base + AW'(1) : window_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			span_q       <= '0;
			ctl_s1.valid <= 1'b0;
			ctl_s1.last  <= 1'b0;
		end else if (accept) begin
			seen_q       <= seen_next;
			span_q       <= span_next;
			ctl_s1.valid <= emit;
			ctl_s1.last  <= samples.last_sample;
		end else if (out_free) begin
			// beat moved on to the output register
			ctl_s1.valid <= 1'b0;
		end
	end

	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		if (k == 0) begin : g_head
			swm_cell #(
				.SAMPLE_WIDTH(SAMPLE_WIDTH)
			) u_cell (
				.clk      (clk),
				.en       (accept),
				.start_req(samples.start_req),
				.sample   (samples.sample),
				.prev_max (samples.sample),
				.max_q    (cell_max[k])
			);
		end else begin : g_body
			swm_cell #(
				.SAMPLE_WIDTH(SAMPLE_WIDTH)
			) u_cell (
				.clk      (clk),
				.en       (accept),
				.start_req(samples.start_req),
				.sample   (samples.sample),
				.prev_max (cell_max[k-1]),
				.max_q    (cell_max[k])
			);
		end
	end

	swm_tap #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.IW          (IW)
	) u_tap (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.tap    (tap),
		.cells  (cell_max),
		.free   (out_free),
		.results(results)
	);

endmodule
